// ===== src/uart_line_assembler_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Line assembler queue: assertion macros
// Concurrent checks on clk; the reset-qualified form is skipped while rst_n
// is low. Both forms compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef UART_LINE_ASSEMBLER_QUEUE_DEFINES_SVH
`define UART_LINE_ASSEMBLER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// check only out of reset
`define ULAQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define ULAQ_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ULAQ_ASSERT_RST(lbl, prop, msg)
`define ULAQ_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

// ===== src/ulaq_pkg.sv =====
// ----------------------------------------------------------------------------
// Line assembler queue package
// Sizes, character and result codes, and the word types shared by the
// front, the command queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package ulaq_pkg;

  // sizes
  localparam int LINE_BYTES  = 64;
  localparam int QUEUE_SLOTS = 4;
  localparam int CMDQ_DEPTH  = 4;

  localparam int FILL_W  = $clog2(LINE_BYTES);
  localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
  localparam int ADDR_W  = $clog2(QUEUE_SLOTS * LINE_BYTES);
  localparam int CMDQ_W  = $clog2(CMDQ_DEPTH);

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_BYTES - 1);

  // characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // input commands
  localparam logic CMD_RX_BYTE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_ZERO    = 3'd1;
  localparam logic [2:0] KIND_NONE    = 3'd2;
  localparam logic [2:0] KIND_STORED  = 3'd3;
  localparam logic [2:0] KIND_DROPPED = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic [7:0] max_len;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [5:0] line_length;
    logic       last;
  } out_word_t;

  // classified work for the back
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_EOL  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;      // character for OP_BYTE
    logic             lim_none;  // read with max_len of zero
    logic [FILL_W-1:0] lim;      // read length limit
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

`default_nettype wire

// ===== src/ulaq_front.sv =====
// ----------------------------------------------------------------------------
// Line assembler queue: front
// Accepts input words, drops carriage returns and turns the rest into
// commands for the back, with the read length limit worked out ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module ulaq_front import ulaq_pkg::*; (
  input  wire logic     in_valid,
  output logic          in_stall,
  input  in_word_t      in_word,
  input  wire logic     q_full,
  output cmd_req_t      q_push
);

  logic [7:0] len_m1;
  logic       is_cr;

  assign in_stall = q_full;
  assign len_m1   = in_word.max_len - 8'd1;
  assign is_cr    = (in_word.command == CMD_RX_BYTE) && (in_word.rx_byte == CH_CR);

  always_comb begin
    q_push.valid        = in_valid && !q_full && !is_cr;
    q_push.cmd.data     = in_word.rx_byte;
    q_push.cmd.lim_none = (in_word.max_len == 8'd0);
    q_push.cmd.lim      = (len_m1 > 8'(LINE_BYTES - 1)) ? FILL_MAX : len_m1[FILL_W-1:0];
    if (in_word.command == CMD_READ) begin
      q_push.cmd.op = OP_READ;
    end else if (in_word.rx_byte == CH_LF) begin
      q_push.cmd.op = OP_EOL;
    end else begin
      q_push.cmd.op = OP_BYTE;
    end
  end

endmodule

`default_nettype wire

// ===== src/ulaq_cmdq.sv =====
// ----------------------------------------------------------------------------
// Line assembler queue: command queue
// Short first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ulaq_cmdq import ulaq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cmd_req_t  push,
  output logic      full,
  output cmd_req_t  head,
  input  wire logic pop
);

  cmd_t              entry_r [CMDQ_DEPTH];
  logic [CMDQ_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_W:0]   count_r,  count_nxt;

  function automatic logic [CMDQ_W-1:0] ptr_inc(input logic [CMDQ_W-1:0] p);
    ptr_inc = (p == CMDQ_W'(CMDQ_DEPTH - 1)) ? '0 : p + CMDQ_W'(1);
  endfunction

  assign full       = (count_r == (CMDQ_W+1)'(CMDQ_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.valid ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + (CMDQ_W+1)'(1);
    end else if (pop && !push.valid) begin
      count_nxt = count_r - (CMDQ_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ulaq_back.sv =====
// ----------------------------------------------------------------------------
// Line assembler queue: back
// Builds lines straight into the free ring slot, commits them on line feed
// and streams popped lines from slot memory one word per cycle if unstalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ulaq_back import ulaq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic notify_enable,
  input  cmd_req_t  head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } back_state_t;

  logic [7:0]        slot_mem [QUEUE_SLOTS * LINE_BYTES];
  logic [FILL_W-1:0] slot_len_r [QUEUE_SLOTS];

  back_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [SLOT_W-1:0] rs_r, rs_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic [7:0]        rdata_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              out_free, pend_take, issue, mem_we, len_we;
  logic              emit;
  logic [2:0]        emit_kind;
  logic [SLOT_W-1:0] ws_inc, rs_inc;
  logic [FILL_W-1:0] slot_len, rd_len, cnt_inc;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    slot_base = ADDR_W'(s) * ADDR_W'(LINE_BYTES);
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign pend_take = pend_r && out_free;
  assign ws_inc    = slot_inc(ws_r);
  assign rs_inc    = slot_inc(rs_r);
  assign slot_len  = slot_len_r[rs_r];
  assign rd_len    = (slot_len > head.cmd.lim) ? head.cmd.lim : slot_len;
  assign cnt_inc   = cnt_r + FILL_W'(1);
  assign wr_addr   = slot_base(ws_r) + ADDR_W'(fill_r);
  assign rd_addr   = base_r + ADDR_W'(cnt_r);

  // a command that may emit waits for a free output register
  assign pop   = (state_r == ST_IDLE) && head.valid &&
                 ((head.cmd.op == OP_BYTE) || out_free);
  assign issue = (state_r == ST_STREAM) && (cnt_r != len_r) && (!pend_r || pend_take);

  always_comb begin
    state_nxt     = state_r;
    ws_nxt        = ws_r;
    rs_nxt        = rs_r;
    fill_nxt      = fill_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    mem_we        = 1'b0;
    len_we        = 1'b0;
    emit          = 1'b0;
    emit_kind     = KIND_NONE;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (head.cmd.op)
            OP_BYTE: begin
              // overlong line: drop it together with this character
              if (fill_r != FILL_MAX) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + FILL_W'(1);
              end else begin
                fill_nxt = '0;
              end
            end
            OP_EOL: begin
              if (fill_r != '0) begin
                if (ws_inc != rs_r) begin
                  len_we    = 1'b1;
                  ws_nxt    = ws_inc;
                  emit      = notify_enable;
                  emit_kind = KIND_STORED;
                end else begin
                  emit      = 1'b1;
                  emit_kind = KIND_DROPPED;
                end
              end
              fill_nxt = '0;
            end
            OP_READ: begin
              if (head.cmd.lim_none || (rs_r == ws_r)) begin
                emit      = 1'b1;
                emit_kind = KIND_NONE;
              end else begin
                rs_nxt = rs_inc;
                if (rd_len == '0) begin
                  emit      = 1'b1;
                  emit_kind = KIND_ZERO;
                end else begin
                  state_nxt = ST_STREAM;
                  base_nxt  = slot_base(rs_r);
                  len_nxt   = rd_len;
                  cnt_nxt   = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_STREAM: begin
        if (issue) begin
          cnt_nxt       = cnt_inc;
          pend_nxt      = 1'b1;
          pend_last_nxt = (cnt_inc == len_r);
        end else begin
          if (pend_take) begin
            pend_nxt = 1'b0;
          end
          // all bytes read and the last one handed on
          if ((cnt_r == len_r) && (!pend_r || pend_take)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (pend_take) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.kind        = KIND_BYTE;
      out_word_nxt.out_byte    = rdata_r;
      out_word_nxt.line_length = 6'(len_r);
      out_word_nxt.last        = pend_last_r;
    end else if (emit) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.kind        = emit_kind;
      out_word_nxt.out_byte    = 8'd0;
      out_word_nxt.line_length = 6'd0;
      out_word_nxt.last        = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= head.cmd.data;
    end
    if (issue) begin
      rdata_r <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      slot_len_r[ws_r] <= fill_r;
    end
    base_r      <= base_nxt;
    cnt_r       <= cnt_nxt;
    len_r       <= len_nxt;
    pend_last_r <= pend_last_nxt;
    out_word_r  <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= '0;
      rs_r        <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      rs_r        <= rs_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== src/uart_line_assembler_queue.sv =====
// ----------------------------------------------------------------------------
// Line assembler queue
// Assembles received characters into lines, queues finished lines in a ring
// of slots and streams the oldest line out on a read command.
// ----------------------------------------------------------------------------
//  channel  | ports                          | word
//  ---------+--------------------------------+---------------------------
//  input    | in_valid / in_stall / in_word  | command, rx_byte, max_len
//  result   | out_valid / out_stall/ out_word| kind, out_byte, line_length, last
//  config   | cfg_wr_en / cfg_wr_data        | notify_enable
//
//  A received character is taken by the back when idle, a line feed or a read
//  once the output register is free too. A read streams one word per cycle
//  while the output is not stalled, after the setup state and the registered
//  slot memory read. A four-word command queue lets input words arrive during
//  a read. Reset clears pointers, fill count and valid flags; the slot memory
//  needs no clearing. A stalled output holds the back while the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none
`include "uart_line_assembler_queue_defines.svh"

module uart_line_assembler_queue import ulaq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  logic     notify_r, notify_nxt;
  cmd_req_t q_push;
  cmd_req_t q_head;
  logic     q_full;
  logic     q_pop;

  assign notify_nxt = cfg_wr_en ? cfg_wr_data : notify_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notify_r <= 1'b0;
    end else begin
      notify_r <= notify_nxt;
    end
  end

  ulaq_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  ulaq_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  ulaq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .notify_enable (notify_r),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );

  `ULAQ_ASSERT_ALL(a_no_push_full, q_push.valid |-> !q_full, "push into full command queue")
  `ULAQ_ASSERT_RST(a_pop_valid, q_pop |-> q_head.valid, "pop from empty command queue")
  `ULAQ_ASSERT_RST(a_single_last, (out_valid && (out_word.kind != KIND_BYTE)) |-> out_word.last, "non-byte result without last")
  `ULAQ_ASSERT_RST(a_kind_range, out_valid |-> (out_word.kind <= KIND_DROPPED), "result kind out of range")

endmodule

`default_nettype wire

// ===== tb/ulaq_line_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line assembler queue checker
// Watches the input, result and register ports, keeps its own copy of the
// line buffer, slot ring and notify bit, and compares every result word
// with the oldest predicted word.
// ----------------------------------------------------------------------------

module ulaq_line_checker import ulaq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  output int        fail_count,
  output int        pending_count,
  output int        checked_count
);

  logic [7:0]        line_chars [LINE_BYTES];
  logic [FILL_W-1:0] line_fill;
  logic [7:0]        slot_chars [QUEUE_SLOTS][LINE_BYTES];
  logic [FILL_W-1:0] slot_len   [QUEUE_SLOTS];
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic              notify_on;

  out_word_t expected_words [$];
  int        mismatch_count = 0;
  int        result_count   = 0;

  assign fail_count = mismatch_count;

  function automatic out_word_t make_word(logic [2:0] kind, logic [7:0] data,
                                          logic [FILL_W-1:0] len, logic last);
    out_word_t w;
    w.kind        = kind;
    w.out_byte    = data;
    w.line_length = len;
    w.last        = last;
    return w;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic predict_word(input in_word_t w);
    logic [SLOT_W-1:0] next_slot;
    logic [SLOT_W-1:0] src_slot;
    int                keep;
    next_slot = SLOT_W'((int'(wr_slot) + 1) % QUEUE_SLOTS);
    if (w.command == CMD_RX_BYTE) begin
      if (w.rx_byte == CH_LF) begin
        // empty lines vanish without a word
        if (line_fill != '0) begin
          if (next_slot != rd_slot) begin
            for (int i = 0; i < LINE_BYTES; i++) slot_chars[wr_slot][i] = line_chars[i];
            slot_len[wr_slot] = line_fill;
            wr_slot = next_slot;
            if (notify_on) expected_words.push_back(make_word(KIND_STORED, 8'h00, '0, 1'b1));
          end else begin
            expected_words.push_back(make_word(KIND_DROPPED, 8'h00, '0, 1'b1));
          end
        end
        line_fill = '0;
      end else if (w.rx_byte != CH_CR) begin
        // a character on a full buffer throws the whole line away
        if (line_fill < FILL_MAX) begin
          line_chars[line_fill] = w.rx_byte;
          line_fill = line_fill + 1'b1;
        end else begin
          line_fill = '0;
        end
      end
    end else begin
      if (w.max_len == 8'd0 || rd_slot == wr_slot) begin
        expected_words.push_back(make_word(KIND_NONE, 8'h00, '0, 1'b1));
      end else begin
        keep = int'(slot_len[rd_slot]);
        if (keep > int'(w.max_len) - 1) keep = int'(w.max_len) - 1;
        if (keep > LINE_BYTES - 1) keep = LINE_BYTES - 1;
        src_slot = rd_slot;
        rd_slot  = SLOT_W'((int'(rd_slot) + 1) % QUEUE_SLOTS);
        if (keep == 0) begin
          expected_words.push_back(make_word(KIND_ZERO, 8'h00, '0, 1'b1));
        end else begin
          for (int i = 0; i < keep; i++)
            expected_words.push_back(make_word(KIND_BYTE, slot_chars[src_slot][i],
                                               FILL_W'(keep), i == keep - 1));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      line_fill = '0;
      wr_slot   = '0;
      rd_slot   = '0;
      notify_on = 1'b0;
      expected_words.delete();
    end else begin
      // compare before predicting: no word can leave on the edge its input enters
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d byte %0h length %0d last %0b",
                 out_word.kind, out_word.out_byte, out_word.line_length, out_word.last);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_word.kind));
          check_field("out_byte", want.out_byte, out_word.out_byte);
          check_field("line_length", 8'(want.line_length), 8'(out_word.line_length));
          check_field("last", 8'(want.last), 8'(out_word.last));
        end
        result_count++;
      end
      if (cfg_wr_en) notify_on = cfg_wr_data;
      if (in_valid && !in_stall) predict_word(in_word);
    end
    pending_count <= expected_words.size();
    checked_count <= result_count;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line assembler queue testbench
// Drives directed and random line traffic and read commands with random
// gaps and output stalls, across notify settings; the checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------

module tb_top;
  import ulaq_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_WORDS  = 150;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  in_word_t  in_word     = '0;
  logic      out_stall   = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;

  int fail_count;
  int pending_count;
  int checked_count;
  int cycle_count = 0;
  int stall_left  = 0;
  int words_sent  = 0;
  int reads_sent  = 0;

  uart_line_assembler_queue uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ulaq_line_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uart_line_assembler_queue verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 99) < 30);
      stall_left <= pick_gap();
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic push_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (w.command == CMD_READ) reads_sent++;
  endtask

  task automatic push_rx(input logic [7:0] c);
    in_word_t w;
    w.command = CMD_RX_BYTE;
    w.rx_byte = c;
    w.max_len = 8'($urandom_range(0, 255));
    push_word(w);
  endtask

  task automatic push_read(input logic [7:0] limit);
    in_word_t w;
    w.command = CMD_READ;
    w.rx_byte = 8'($urandom_range(0, 255));
    w.max_len = limit;
    push_word(w);
  endtask

  // random characters with a stray carriage return now and then, closed by LF
  task automatic send_line(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
      if ($urandom_range(0, 99) < 5) push_rx(CH_CR);
      push_rx(c);
    end
    push_rx(CH_LF);
  endtask

  // drain results, then give queued characters time to clear the back
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_notify(input logic value);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int r;
    int random_start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: notify off after reset
    push_read(8'd255);          // empty ring
    push_rx(CH_LF);             // empty line
    push_rx(8'h41);
    push_rx(CH_CR);
    push_rx(CH_LF);             // stored silently
    push_read(8'd0);            // zero limit, nothing popped
    push_read(8'd1);            // pops, zero returned length
    write_notify(1'b1);
    for (int i = 0; i < 3; i++) begin
      push_rx(8'h78);
      push_rx(CH_LF);
    end
    push_rx(8'h79);
    push_rx(CH_LF);             // ring full
    push_read(8'd255);
    push_read(8'd2);
    push_rx(8'hFF);
    push_rx(8'h00);
    push_rx(CH_LF);
    push_read(8'd255);
    push_read(8'd255);
    push_read(8'd255);          // empty again

    random_start = words_sent;
    for (int phase = 0; phase < 4; phase++) begin
      write_notify(phase[0]);
      if (phase == 1) begin
        send_line(LINE_BYTES - 1);   // longest line that fits
        push_read(8'd255);
      end
      if (phase == 2) send_line(LINE_BYTES + 1);  // overflow, then a short tail
      while (words_sent < random_start + RANDOM_WORDS * (phase + 1) / 4) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          if ($urandom_range(0, 99) < 4) send_line($urandom_range(55, 66));
          else send_line($urandom_range(1, 8));
        end else if (r < 80) begin
          r = $urandom_range(0, 99);
          if (r < 10) push_read(8'd0);
          else if (r < 20) push_read(8'd1);
          else if (r < 30) push_read(8'd255);
          else if (r < 40) push_read(8'($urandom_range(64, 70)));
          else push_read(8'($urandom_range(2, 12)));
        end else begin
          push_rx(8'($urandom_range(0, 255)));
        end
      end
    end

    settle_idle();
    $display("Sent %0d input words, %0d of them reads, over notify off and on phases",
             words_sent, reads_sent);
    $display("Checked %0d result words against the predicted stream", checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("uart_line_assembler_queue verification clean");
    end else begin
      $display("uart_line_assembler_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ulaq_pkg.sv
src/ulaq_front.sv
src/ulaq_cmdq.sv
src/ulaq_back.sv
src/uart_line_assembler_queue.sv
tb/ulaq_line_checker.sv
tb/tb_top.sv
